// ===== rtl/core/max_intensity_projection_z_unit_macros.svh =====
// Assertion macros shared by the projection unit's RTL files.
// Self-contained: no other file is needed by this header.
`ifndef MAX_INTENSITY_PROJECTION_Z_UNIT_MACROS_SVH
`define MAX_INTENSITY_PROJECTION_Z_UNIT_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define MIPZ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define MIPZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mipz_pkg.sv =====
// Shared types and fixed constants of the max intensity projection unit.
// No dependencies; imported by every module of the unit but mipz_ram.
package mipz_pkg;

    localparam int PIX_W       = 8;   // voxel and projected pixel width
    localparam int SIZE_W      = 9;   // width and height registers
    localparam int SLICE_CFG_W = 11;  // slice count register
    localparam int POS_W       = 8;   // column and row counters
    localparam int SLICE_POS_W = 10;  // slice counter
    localparam int SUM_W       = 16;  // row * width + col before reduction
    localparam int DIM_MAX     = 256; // largest width and height
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // Output queue
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = 3;
    localparam int Q_CNT_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SLICES = 2'd2
    } cfg_reg_t;

    // Clamped volume dimensions
    typedef struct packed {
        logic [SIZE_W-1:0]      width;
        logic [SIZE_W-1:0]      height;
        logic [SLICE_CFG_W-1:0] slices;
    } dims_t;

    // Per-item control traveling down the pipeline
    typedef struct packed {
        logic [PIX_W-1:0] voxel;
        logic             first_slice;
        logic             emit;
        logic             frame_last;
    } item_t;

    // Result item held in the output queue
    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pixel;
    } out_t;

endpackage

// ===== rtl/core/mipz_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mipz_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mipz_addr.sv =====
// Position counters and the pixel address pipeline of the projection unit.
// Depends on mipz_pkg.
module mipz_addr #(
    parameter int  MAX_SLICE_PIXELS = 65536,
    localparam int ADDR_W = (MAX_SLICE_PIXELS > 1) ? $clog2(MAX_SLICE_PIXELS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic [mipz_pkg::PIX_W-1:0]    voxel,
    input  mipz_pkg::dims_t               dims,
    output logic [2:0]                    stage_vld,
    output logic                          rd_vld,
    output logic [ADDR_W-1:0]             rd_addr,
    output mipz_pkg::item_t               rd_item
);
    import mipz_pkg::*;

    localparam logic [39:0] MOD_N = 40'(MAX_SLICE_PIXELS);

    // Eight restoring steps of sum mod N, shifts lo+7 down to lo.
    function automatic logic [SUM_W-1:0] reduce_steps(input logic [SUM_W-1:0] v,
                                                      input int lo);
        logic [SUM_W-1:0] x;
        logic [39:0]      sub;
        x = v;
        for (int k = 7; k >= 0; k--) begin
            sub = MOD_N << (k + lo);
            if (40'(x) >= sub) begin
                x = x - SUM_W'(sub);
            end
        end
        return x;
    endfunction

    logic [POS_W-1:0]       col_reg, col_next;
    logic [POS_W-1:0]       row_reg, row_next;
    logic [SLICE_POS_W-1:0] slice_reg, slice_next;
    logic                   last_col, last_row, last_slice;
    logic [SUM_W:0]         row_base;
    logic [SUM_W:0]         sum_full;

    logic             s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [SUM_W-1:0] s1_sum_reg, s2_sum_reg;
    logic [SUM_W-1:0] s2_sum_next, s3_sum_next;
    logic [ADDR_W-1:0] s3_addr_reg;
    item_t            s1_item_reg, s2_item_reg, s3_item_reg;
    item_t            s1_item_next;

    always_comb begin
        last_col   = (SIZE_W'(col_reg) + SIZE_W'(1)) >= dims.width;
        last_row   = (SIZE_W'(row_reg) + SIZE_W'(1)) >= dims.height;
        last_slice = (SLICE_CFG_W'(slice_reg) + SLICE_CFG_W'(1)) >= dims.slices;

        col_next   = col_reg;
        row_next   = row_reg;
        slice_next = slice_reg;
        if (in_fire) begin
            if (!last_col) begin
                col_next = col_reg + POS_W'(1);
            end else begin
                col_next = '0;
                if (!last_row) begin
                    row_next = row_reg + POS_W'(1);
                end else begin
                    row_next   = '0;
                    slice_next = last_slice ? '0 : slice_reg + SLICE_POS_W'(1);
                end
            end
        end

        // Largest value is 255 * 256 + 255, so the low SUM_W bits are exact
        row_base = (SUM_W+1)'(row_reg) * (SUM_W+1)'(dims.width);
        sum_full = row_base + (SUM_W+1)'(col_reg);

        s1_item_next.voxel       = voxel;
        s1_item_next.first_slice = (slice_reg == '0);
        s1_item_next.emit        = last_slice;
        s1_item_next.frame_last  = last_col && last_row;

        s2_sum_next = reduce_steps(s1_sum_reg, 8);
        s3_sum_next = reduce_steps(s2_sum_reg, 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            slice_reg  <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            slice_reg  <= slice_next;
            s1_vld_reg <= in_fire;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_sum_reg  <= sum_full[SUM_W-1:0];
        s1_item_reg <= s1_item_next;
        s2_sum_reg  <= s2_sum_next;
        s2_item_reg <= s1_item_reg;
        s3_addr_reg <= ADDR_W'(s3_sum_next);
        s3_item_reg <= s2_item_reg;
    end

    assign stage_vld = {s3_vld_reg, s2_vld_reg, s1_vld_reg};
    assign rd_vld    = s3_vld_reg;
    assign rd_addr   = s3_addr_reg;
    assign rd_item   = s3_item_reg;

endmodule

// ===== rtl/core/mipz_queue.sv =====
// Small output queue that decouples result items from the sink's stalls.
// Depends on mipz_pkg.
module mipz_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  mipz_pkg::out_t                 push_data,
    input  logic                           pop,
    output logic                           out_vld,
    output mipz_pkg::out_t                 out_data,
    output logic [mipz_pkg::Q_CNT_W-1:0]   count
);
    import mipz_pkg::*;

    out_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               pop_ok;

    always_comb begin
        pop_ok      = pop && (cnt_reg != '0);
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop_ok);
        cnt_next    = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop_ok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_vld  = (cnt_reg != '0);
    assign out_data = slot_reg[rd_ptr_reg];
    assign count    = cnt_reg;

endmodule

// ===== rtl/core/max_intensity_projection_z_unit.sv =====
// Top level of the max intensity projection unit along z.
// Depends on mipz_pkg, mipz_addr, mipz_ram, mipz_queue and the macros header.
//
//   Channel   Direction  Payload                           Handshake
//   s_        in         tdata[7:0] = voxel                s_tvalid / s_tready
//   m_        out        tdata[7:0] = projected_pixel,     m_tvalid / m_tready
//                        tlast      = frame_last
//   cfg_      in         cfg_idx selects the size reg,     cfg_wen, no wait
//                        cfg_wdata carries the value
//
// Sustained rate is one voxel per cycle while s_tready is high, set by the single
// read-modify-write of the running-max RAM per voxel; a one-entry bypass covers
// back-to-back hits on one pixel. Reset clears the position counters and loads a
// 256 x 256 x 1 volume; the RAM is not cleared, as every pixel is written in the
// first slice. A stalled sink fills the eight-item output queue; s_tready drops once
// the queue plus the items in flight could overfill it.
`include "max_intensity_projection_z_unit_macros.svh"

module max_intensity_projection_z_unit #(
    parameter int MAX_SLICE_PIXELS = 65536,
    parameter int MAX_SLICES       = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Size registers: width_pixels, height_pixels, slice_count
    input  logic                               cfg_wen,
    input  logic [mipz_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [mipz_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Voxel stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mipz_pkg::PIX_W-1:0]         s_tdata,   // [7:0] voxel
    // Projected pixels
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mipz_pkg::PIX_W-1:0]         m_tdata,   // [7:0] projected_pixel
    output logic                               m_tlast    // frame_last
);
    import mipz_pkg::*;

    localparam int ADDR_W = (MAX_SLICE_PIXELS > 1) ? $clog2(MAX_SLICE_PIXELS) : 1;
    localparam int ZMAX   = (MAX_SLICES < 1024) ? MAX_SLICES : 1024;

    // A size of zero acts as one; oversized values saturate.
    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (v > SIZE_W'(DIM_MAX)) begin
            return SIZE_W'(DIM_MAX);
        end
        return v;
    endfunction

    function automatic logic [SLICE_CFG_W-1:0] clamp_slices(input logic [SLICE_CFG_W-1:0] v);
        if (v == '0) begin
            return SLICE_CFG_W'(1);
        end
        if (v > SLICE_CFG_W'(ZMAX)) begin
            return SLICE_CFG_W'(ZMAX);
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Size registers, stored already clamped
    // ------------------------------------------------------------------
    dims_t dims_reg, dims_next;

    always_comb begin
        dims_next = dims_reg;
        if (cfg_wen) begin
            case (cfg_reg_t'(cfg_idx))
                REG_WIDTH:  dims_next.width  = clamp_dim(cfg_wdata[SIZE_W-1:0]);
                REG_HEIGHT: dims_next.height = clamp_dim(cfg_wdata[SIZE_W-1:0]);
                REG_SLICES: dims_next.slices = clamp_slices(cfg_wdata);
                default:    dims_next = dims_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg.width  <= SIZE_W'(DIM_MAX);
            dims_reg.height <= SIZE_W'(DIM_MAX);
            dims_reg.slices <= SLICE_CFG_W'(1);
        end else begin
            dims_reg <= dims_next;
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance: hold off while the queue could overfill
    // ------------------------------------------------------------------
    logic                in_fire;
    logic [2:0]          stage_vld;
    logic [2:0]          inflight;
    logic [Q_CNT_W:0]    occupancy;
    logic [Q_CNT_W-1:0]  q_cnt;
    logic                s4_vld_reg;

    always_comb begin
        inflight  = 3'(stage_vld[0]) + 3'(stage_vld[1]) + 3'(stage_vld[2])
                  + 3'(s4_vld_reg);
        occupancy = (Q_CNT_W+1)'(q_cnt) + (Q_CNT_W+1)'(inflight);
    end

    assign s_tready = occupancy < (Q_CNT_W+1)'(Q_DEPTH);
    assign in_fire  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Counters and address pipeline; the last stage issues the RAM read
    // ------------------------------------------------------------------
    logic              s3_vld;
    logic [ADDR_W-1:0] s3_addr;
    item_t             s3_item;

    mipz_addr #(
        .MAX_SLICE_PIXELS (MAX_SLICE_PIXELS)
    ) u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .voxel     (s_tdata),
        .dims      (dims_reg),
        .stage_vld (stage_vld),
        .rd_vld    (s3_vld),
        .rd_addr   (s3_addr),
        .rd_item   (s3_item)
    );

    // ------------------------------------------------------------------
    // Modify and write back
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] s4_addr_reg;
    item_t             s4_item_reg;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [PIX_W-1:0]  fwd_data_reg;
    logic [PIX_W-1:0]  ram_rdata;
    logic [PIX_W-1:0]  stored;
    logic [PIX_W-1:0]  new_max;

    mipz_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SLICE_PIXELS)
    ) u_running_max (
        .aclk  (aclk),
        .we    (s4_vld_reg),
        .waddr (s4_addr_reg),
        .wdata (new_max),
        .raddr (s3_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        // The item directly ahead writes while this one reads: take its value
        stored = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        if (s4_item_reg.first_slice) begin
            new_max = s4_item_reg.voxel;
        end else begin
            new_max = (s4_item_reg.voxel > stored) ? s4_item_reg.voxel : stored;
        end
        fwd_hit_next = s3_vld && s4_vld_reg && (s3_addr == s4_addr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            s4_vld_reg  <= s3_vld;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        s4_addr_reg  <= s3_addr;
        s4_item_reg  <= s3_item;
        fwd_data_reg <= new_max;
    end

    // ------------------------------------------------------------------
    // Output queue: push only during the last slice
    // ------------------------------------------------------------------
    logic q_push;
    logic q_pop;
    out_t q_in;
    out_t q_out;

    assign q_push     = s4_vld_reg && s4_item_reg.emit;
    assign q_pop      = m_tvalid && m_tready;
    assign q_in.last  = s4_item_reg.frame_last;
    assign q_in.pixel = new_max;

    mipz_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .out_vld   (m_tvalid),
        .out_data  (q_out),
        .count     (q_cnt)
    );

    assign m_tdata = q_out.pixel;
    assign m_tlast = q_out.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MIPZ_ASSERT_NOW(a_queue_room, aclk, aresetn, q_push && !q_pop,
        q_cnt != Q_CNT_W'(Q_DEPTH), "result pushed into a full queue")
    `MIPZ_ASSERT_NEXT(a_fwd_capture, aclk, aresetn,
        s3_vld && s4_vld_reg && (s3_addr == s4_addr_reg), fwd_hit_reg,
        "same-pixel hit not bypassed")
    `MIPZ_ASSERT_NEXT(a_pipe_no_drop, aclk, aresetn, s3_vld, s4_vld_reg,
        "item lost between read and write back")
    `MIPZ_ASSERT_NOW(a_fwd_source, aclk, aresetn, fwd_hit_reg, $past(s4_vld_reg),
        "bypass without a preceding write")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for max_intensity_projection_z_unit.
// Holds its own projection predictor, a voxel driver and a pixel monitor;
// depends on mipz_pkg and the unit's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mipz_pkg::*;

    localparam int PIXEL_ENTRIES = 65536;  // running-max store depth
    localparam int SLICE_LIMIT   = 1024;   // largest slice count
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // index with no register
    localparam int DRAIN_CYCLES  = 8;      // pad after the last pixel for items still in flight

    // One expected projected pixel
    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } proj_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // Block inputs, all known from time zero
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tready  = 1'b0;

    // Block outputs
    logic             s_tready;
    logic             m_tvalid;
    logic [PIX_W-1:0] m_tdata;
    logic             m_tlast;

    max_intensity_projection_z_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] voxel
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] projected_pixel
        .m_tlast   (m_tlast)    // frame_last
    );

    // ------------------------------------------------------------------
    // Predictor state: size registers as written, position counters and
    // the per-pixel running maximum.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]      cfg_width  = 9'd256;
    logic [SIZE_W-1:0]      cfg_height = 9'd256;
    logic [SLICE_CFG_W-1:0] cfg_slices = 11'd1;
    int unsigned            col_at     = 0;
    int unsigned            row_at     = 0;
    int unsigned            slice_at   = 0;
    logic [PIX_W-1:0]       peak_mem [PIXEL_ENTRIES];

    proj_t      pixel_q[$];   // projected pixels still owed by the block
    logic [7:0] voxel_q[$];   // voxels waiting for the driver

    int errors       = 0;
    int voxels_in    = 0;
    int pixels_out   = 0;
    int reg_writes   = 0;
    int queued_items = 0;
    bit quiet        = 1'b0;  // no idling on either side
    bit pressure_go  = 1'b0;
    logic sink_hold  = 1'b0;
    int src_gap      = 0;
    int sink_gap     = 0;

    // Zero acts as one; anything above the top saturates.
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned eff_width();
        return clamp_dim(cfg_width, DIM_MAX);
    endfunction

    function automatic int unsigned eff_height();
        return clamp_dim(cfg_height, DIM_MAX);
    endfunction

    function automatic int unsigned eff_slices();
        return clamp_dim(cfg_slices, SLICE_LIMIT);
    endfunction

    // Append one voxel for the driver and count it.
    task automatic queue_voxel(input logic [7:0] v);
        voxel_q = {voxel_q, v};
        queued_items++;
    endtask

    // Fold one accepted voxel into the running maximum; queue a pixel
    // whenever it lands in the last slice.
    task automatic project_voxel(input logic [PIX_W-1:0] v);
        int unsigned w;
        int unsigned h;
        int unsigned z;
        int unsigned addr;
        logic [PIX_W-1:0] m;
        bit end_col;
        bit end_row;
        bit end_slice;
        proj_t p;
        w = eff_width();
        h = eff_height();
        z = eff_slices();
        addr = (row_at * w + col_at) % PIXEL_ENTRIES;
        end_col   = (col_at + 1 >= w);
        end_row   = (row_at + 1 >= h);
        end_slice = (slice_at + 1 >= z);
        // first slice stores the voxel as is, later ones keep the larger
        if (slice_at == 0) begin
            m = v;
        end else begin
            m = peak_mem[addr];
            if (v > m)
                m = v;
        end
        peak_mem[addr] = m;
        if (end_slice) begin
            p.pixel = m;
            p.last  = end_col && end_row;
            pixel_q = {pixel_q, p};
        end
        // advance x, then y, then z; wrap for the next volume
        if (!end_col) begin
            col_at++;
        end else begin
            col_at = 0;
            if (!end_row) begin
                row_at++;
            end else begin
                row_at = 0;
                slice_at = end_slice ? 0 : slice_at + 1;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Voxel driver: load the next item once the slot is free, with random
    // bursts of idle cycles between items.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                project_voxel(s_tdata);
                voxels_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (voxel_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= voxel_q.pop_front();
                    if (!quiet && $urandom_range(0, 6) == 0)
                        src_gap = $urandom_range(1, 10);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel monitor: check each accepted item against the oldest expected
    // pixel, then pick the ready level for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : pixel_sink
        proj_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                pixels_out++;
                if (pixel_q.size() == 0) begin
                    report_mismatch($sformatf("pixel %0h last %0b with nothing expected",
                                              m_tdata, m_tlast));
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata !== want.pixel)
                        report_mismatch($sformatf("projected_pixel %0h, expected %0h",
                                                  m_tdata, want.pixel));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  m_tlast, want.last));
                end
            end
            if (sink_hold) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 10);
            end
        end
    end

    // Long sink stall: hold ready low while the driver keeps offering, so
    // the output queue fills and s_tready drops.
    initial begin : sink_stall
        int held;
        wait (pressure_go);
        @(posedge aclk);
        sink_hold <= 1'b1;
        for (held = 0; held < 200; held++)
            @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // Write one size register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = val[SIZE_W-1:0];
            REG_HEIGHT: cfg_height = val[SIZE_W-1:0];
            REG_SLICES: cfg_slices = val[SLICE_CFG_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Wait until every queued voxel is accepted and every pixel out, then
    // let the pipeline settle so no item without a result is still in flight.
    task automatic wait_drained();
        @(posedge aclk);
        while (voxels_in != queued_items || pixel_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [PIX_W-1:0] rand_voxel();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue n random voxels off the clock edge, then wait for them.
    task automatic feed_voxels(input int unsigned n);
        int unsigned i;
        @(negedge aclk);
        for (i = 0; i < n; i++)
            queue_voxel(rand_voxel());
        wait_drained();
    endtask

    // Small size value: mostly 1..top, sometimes zero, sometimes with the
    // dropped upper bits set.
    function automatic logic [CFG_DATA_W-1:0] small_dim(input int unsigned top);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_DATA_W'(($urandom_range(1, 3) << SIZE_W)
                                        | $urandom_range(1, top));
            default: return CFG_DATA_W'($urandom_range(1, top));
        endcase
    endfunction

    // One random setting: rewrite a subset of registers at a volume
    // boundary, then run whole volumes, at times with a slice count change
    // partway through a volume.
    task automatic random_phase();
        int unsigned w;
        int unsigned h;
        int unsigned z;
        int unsigned k;
        int unsigned nz;
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_WIDTH, small_dim(8));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_HEIGHT, small_dim(8));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_SLICES, ($urandom_range(0, 9) == 0) ? '0
                                  : CFG_DATA_W'($urandom_range(1, 5)));
        w = eff_width();
        h = eff_height();
        z = eff_slices();
        if (z >= 2 && $urandom_range(0, 4) == 0) begin
            // stop after k slices; only the slice count moves, so every
            // pixel read later was written in this volume's first slice
            k = $urandom_range(1, z - 1);
            feed_voxels(k * w * h);
            write_reg(REG_SLICES, CFG_DATA_W'($urandom_range(0, 6)));
            nz = eff_slices();
            feed_voxels(((nz > k) ? nz - k : 1) * w * h);
        end else begin
            feed_voxels($urandom_range(1, 2) * w * h * z);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int phase;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // two 2x1x3 volumes: extremes and alternating bit patterns; the
        // second volume's first slice overwrites what the first left behind
        write_reg(REG_WIDTH, 11'd2);
        write_reg(REG_HEIGHT, 11'd1);
        write_reg(REG_SLICES, 11'd3);
        @(negedge aclk);
        queue_voxel(8'hFF);
        queue_voxel(8'h00);
        queue_voxel(8'h80);
        queue_voxel(8'h01);
        queue_voxel(8'h00);
        queue_voxel(8'hFE);
        queue_voxel(8'h00);
        queue_voxel(8'h00);
        queue_voxel(8'h55);
        queue_voxel(8'hAA);
        queue_voxel(8'hAA);
        queue_voxel(8'h55);
        wait_drained();

        // zero sizes act as one (width 0x200 drops to zero); the unused
        // index must leave everything alone
        write_reg(REG_WIDTH, 11'h200);
        write_reg(REG_HEIGHT, 11'd0);
        write_reg(REG_SLICES, 11'd0);
        write_reg(REG_SPARE, 11'h7FF);
        @(negedge aclk);
        queue_voxel(8'hFF);
        queue_voxel(8'h00);
        wait_drained();

        // cut a 2x1x4 volume short: after two slices drop the count to
        // one, below the slice counter, so the next slice is the last
        write_reg(REG_WIDTH, 11'd2);
        write_reg(REG_SLICES, 11'd4);
        @(negedge aclk);
        queue_voxel(8'h10);
        queue_voxel(8'h20);
        queue_voxel(8'h30);
        queue_voxel(8'h05);
        wait_drained();
        write_reg(REG_SLICES, 11'd1);
        @(negedge aclk);
        queue_voxel(8'h08);
        queue_voxel(8'h40);
        wait_drained();

        phase = 0;
        while (queued_items < 1900) begin
            case (phase)
                0: begin
                    // 8x8 single slice with the long sink stall
                    write_reg(REG_WIDTH, 11'd8);
                    write_reg(REG_HEIGHT, 11'd8);
                    write_reg(REG_SLICES, 11'd1);
                    pressure_go = 1'b1;
                    feed_voxels(64);
                end
                1: begin
                    // deepest volume: oversized count saturates to 1024
                    write_reg(REG_WIDTH, 11'd1);
                    write_reg(REG_HEIGHT, 11'd1);
                    write_reg(REG_SLICES, 11'h7FF);
                    feed_voxels(eff_slices());
                end
                2: begin
                    // widest row: oversized width saturates to 256
                    write_reg(REG_WIDTH, 11'h7FF);
                    write_reg(REG_HEIGHT, 11'd1);
                    write_reg(REG_SLICES, 11'd1);
                    feed_voxels(eff_width());
                end
                3: begin
                    // tallest column at exactly 256 rows
                    write_reg(REG_WIDTH, 11'd1);
                    write_reg(REG_HEIGHT, 11'd256);
                    write_reg(REG_SLICES, 11'd1);
                    feed_voxels(eff_height());
                end
                default: begin
                    if (queued_items >= 1750) begin
                        @(negedge aclk);
                        quiet = 1'b1;
                    end
                    random_phase();
                end
            endcase
            phase++;
        end

        wait_drained();
        $display("covered %0d voxels and %0d projected pixels over %0d register writes",
                 voxels_in, pixels_out, reg_writes);
        $display("sizes from 1x1x1 up to 256 wide, 256 high and 1024 slices, one long sink stall");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mipz_pkg.sv
rtl/core/mipz_ram.sv
rtl/core/mipz_addr.sv
rtl/core/mipz_queue.sv
rtl/core/max_intensity_projection_z_unit.sv
tb/sv/tb.sv
